/* design/kfst_pkg.sv */
// ----------------------------------------------------------------------------
// kfst_pkg: shared types and constants for the keyed FIFO / sorted table
// ----------------------------------------------------------------------------
`default_nettype none
package kfst_pkg;
  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS   = 16;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_FIND   = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_POP    = 3'd3;
  localparam logic [2:0] ACT_PEEK   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_DEL,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

/* design/keyed_fifo_or_sorted_table.sv */
// An unused action or a refused add goes straight to the result. A scan reads
// one slot a cycle; a shift moves each slot by reading it and then writing it
// back. One item at a time: in_stall is high until the item's result is
// loaded, and a stalled earlier result can hold the finished item.
// Reset: count is zero and list_mode is FIFO; the RAMs are not cleared.
// ----------------------------------------------------------------------------
// keyed_fifo_or_sorted_table
// ----------------------------------------------------------------------------
// Table of key/value pairs in slots 0..count-1, held in two one-port-read
// RAMs. Scan finds the slot, then a shift pass moves entries one at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_fifo_or_sorted_table
  import kfst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_list_mode,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_action,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [31:0]           in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_ok,
  output logic [KEY_BITS-1:0]        out_key,
  output logic [31:0]                out_value,
  output logic [4:0]                 out_entry_count
);

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  state_t                state_r, state_nxt;
  logic                  mode_r;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [2:0]            act_r, act_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CNT_BITS-1:0]   idx_r, idx_nxt;   // walk position
  logic [CNT_BITS-1:0]   slot_r, slot_nxt; // target slot
  logic                  rdv_r, rdv_nxt;   // read data valid (slot idx_r-1 in scan/insert, idx_r+1 in delete)
  logic                  ok_r, ok_nxt;
  logic [KEY_BITS-1:0]   okey_r, okey_nxt;
  logic [VALUE_BITS-1:0] oval_r, oval_nxt;
  logic                  ov_r, ov_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;
  logic [CNT_BITS-1:0]   res_cnt_r, res_cnt_nxt;

  logic [IDX_BITS-1:0]   rd_addr;
  logic                  rd_en;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= 1'b0;
      cnt_r   <= '0;
      rdv_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rdv_r   <= rdv_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) mode_r <= cfg_list_mode;
    end
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    slot_r    <= slot_nxt;
    ok_r      <= ok_nxt;
    okey_r    <= okey_nxt;
    oval_r    <= oval_nxt;
    res_ok_r  <= res_ok_nxt;
    res_key_r <= res_key_nxt;
    res_val_r <= res_val_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

  assign cfg_ready       = 1'b1;
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_ok          = res_ok_r;
  assign out_key         = res_key_r;
  assign out_value       = 32'(res_val_r);
  assign out_entry_count = 5'(res_cnt_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    slot_nxt    = slot_r;
    rdv_nxt     = 1'b0;
    ok_nxt      = ok_r;
    okey_nxt    = okey_r;
    oval_nxt    = oval_r;
    ov_nxt      = ov_r;
    res_ok_nxt  = res_ok_r;
    res_key_nxt = res_key_r;
    res_val_nxt = res_val_r;
    res_cnt_nxt = res_cnt_r;
    rd_en       = 1'b0;
    rd_addr     = idx_r[IDX_BITS-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_r[IDX_BITS-1:0];
    wr_key      = key_r;
    wr_val      = val_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_action;
          key_nxt  = in_key;
          val_nxt  = VALUE_BITS'(in_value);
          idx_nxt  = '0;
          ok_nxt   = 1'b0;
          okey_nxt = '0;
          oval_nxt = '0;
          state_nxt = ST_DONE;
          if (in_action == ACT_ADD) begin
            if (cnt_r != CNT_BITS'(CAPACITY)) begin
              if (mode_r) begin
                state_nxt = ST_SCAN;
              end else begin
                slot_nxt  = cnt_r;
                idx_nxt   = cnt_r;
                state_nxt = ST_INS;
              end
            end
          end else if (in_action == ACT_FIND || in_action == ACT_REMOVE ||
                       in_action == ACT_POP || in_action == ACT_PEEK) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue read of slot idx_r, evaluate data of slot idx_r-1
        if (rdv_r) begin
          priority if (act_r == ACT_ADD) begin
            if (!(rd_key < key_r)) begin
              slot_nxt  = idx_r - 1'b1;
              idx_nxt   = cnt_r;
              state_nxt = ST_INS;
            end
          end else if (act_r == ACT_POP || act_r == ACT_PEEK) begin
            ok_nxt   = 1'b1;
            okey_nxt = rd_key;
            oval_nxt = rd_val;
            if (act_r == ACT_POP) begin
              idx_nxt   = '0;
              state_nxt = ST_DEL;
            end else begin
              state_nxt = ST_DONE;
            end
          end else if (rd_key == key_r) begin
            ok_nxt = 1'b1;
            if (act_r == ACT_FIND) begin
              oval_nxt  = rd_val;
              state_nxt = ST_DONE;
            end else begin
              idx_nxt   = idx_r - 1'b1;
              state_nxt = ST_DEL;
            end
          end else if (mode_r && rd_key > key_r) begin
            state_nxt = ST_DONE;
          end
        end
        if (state_nxt == ST_SCAN) begin
          if (idx_r < cnt_r) begin
            rd_en   = 1'b1;
            rdv_nxt = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end else if (act_r == ACT_ADD) begin
            slot_nxt  = cnt_r;
            idx_nxt   = cnt_r;
            state_nxt = ST_INS;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_INS: begin
        // walk down from count: read slot idx-1, write it to slot idx
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_addr = IDX_BITS'(idx_r);
          wr_key  = rd_key;
          wr_val  = rd_val;
          idx_nxt = idx_r - 1'b1;
        end else if (idx_r == slot_r) begin
          wr_en     = 1'b1;
          ok_nxt    = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_BITS'(idx_r - 1'b1);
          rdv_nxt = 1'b1;
        end
      end
      ST_DEL: begin
        // walk up: read slot idx+1, write it to slot idx
        if (rdv_r) begin
          wr_en   = 1'b1;
          wr_key  = rd_key;
          wr_val  = rd_val;
          idx_nxt = idx_r + 1'b1;
        end else if (idx_r + 1'b1 >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_BITS'(idx_r + 1'b1);
          rdv_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the previous beat drains, then load the result register
        if (!ov_r || !out_stall) begin
          ov_nxt      = 1'b1;
          res_ok_nxt  = ok_r;
          res_key_nxt = okey_r;
          res_val_nxt = oval_r;
          res_cnt_nxt = cnt_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire
